FILE: design/lmsd_pkg.sv
`default_nettype none

package lmsd_pkg;

  localparam int ROWS      = 16;
  localparam int ROW_BYTES = 4;
  localparam int COLS      = (ROW_BYTES * 8 >= 32) ? 32 : ROW_BYTES * 8;

  localparam int ROW_W  = 4;
  localparam int COL_W  = 5;
  localparam int BRT_W  = 4;
  localparam int TPR_W  = 8;
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 8;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [31:0] COL_MASK =
    (COLS >= 32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> COLS);

  localparam logic [BRT_W-1:0] BRIGHT_RESET = 4'd5;
  localparam logic [TPR_W-1:0] PERIOD_RESET = 8'd10;

  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SET    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TOGGLE = 2'd3;

  localparam logic [IDX_W-1:0] REG_BRIGHTNESS    = 8'd0;
  localparam logic [IDX_W-1:0] REG_TICKS_PER_ROW = 8'd1;

endpackage

`default_nettype wire

FILE: design/led_matrix_scan_driver.sv
`default_nettype none

// Row-multiplexed LED matrix scanner for 16 rows of 32 columns with a one-bit
// frame store. Each input transfer is either a scan tick or a set, clear or
// toggle of one pixel; each produces exactly one result carrying the output
// enable, the selected row, the latched row data (bit 31 is column 0) and a
// flag that marks a row load. One input transfer is taken every clock cycle
// while the result queue has room, and its result passes through the modify
// stage into that queue. The frame store is a synchronous memory with a
// registered read, modified and written back in the following cycle, with a
// bypass for back-to-back accesses to the same row. A three-entry result queue
// lets input continue while results wait. The frame store reads as zero after
// reset with no clearing pass, and configuration writes are taken every cycle.
module led_matrix_scan_driver
  import lmsd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // pixel_x[4:0], pixel_y[8:5], zero pad
  input  wire logic [ACT_W-1:0]      s_tuser,   // action[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // output_enable[0], row_select[4:1],
                                                // row_bits[36:5], zero pad
  output logic                       m_tuser,   // row_loaded[0]
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  typedef struct packed {
    logic        loaded;
    logic [31:0] bits;
    logic [3:0]  row;
    logic        en;
  } result_t;

  localparam int QDEPTH = 3;

  // configuration
  logic [BRT_W-1:0] brightness;
  logic [TPR_W-1:0] ticks_per_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= BRIGHT_RESET;
      ticks_per_row <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BRIGHTNESS) begin
        brightness <= cfg_data[BRT_W-1:0];
      end else if (cfg_index == REG_TICKS_PER_ROW) begin
        ticks_per_row <= cfg_data[TPR_W-1:0];
      end
    end
  end

  // input unpack
  logic [ACT_W-1:0] in_act;
  logic [COL_W-1:0] in_x;
  logic [ROW_W-1:0] in_y;
  logic             in_xfer;

  assign in_act  = s_tuser;
  assign in_x    = s_tdata[4:0];
  assign in_y    = s_tdata[8:5];
  assign in_xfer = s_tvalid && s_tready;

  // scan state
  logic [TPR_W-1:0] subtick_count, subtick_count_next;
  logic [ROW_W-1:0] scan_row, scan_row_next;
  logic             enable_state, enable_state_next;
  logic             loaded_next;
  logic [ROW_W-1:0] rd_addr;
  logic             pixel_ok;
  logic [TPR_W-1:0] cnt_inc;
  logic [ROW_W:0]   row_inc;

  always_comb begin
    subtick_count_next = subtick_count;
    scan_row_next      = scan_row;
    enable_state_next  = enable_state;
    loaded_next        = 1'b0;
    cnt_inc            = subtick_count + 8'd1;
    row_inc            = {1'b0, scan_row} + 5'd1;
    rd_addr            = in_y;
    pixel_ok           = ({1'b0, in_y} < (ROW_W+1)'(ROWS)) &&
                         ({1'b0, in_x} < (COL_W+1)'(COLS));
    if (in_act == ACT_TICK) begin
      subtick_count_next = cnt_inc;
      if (brightness != '0 && cnt_inc == {4'd0, brightness}) begin
        enable_state_next = 1'b0;
      end
      if (cnt_inc >= ticks_per_row) begin
        subtick_count_next = '0;
        scan_row_next      = (row_inc >= (ROW_W+1)'(ROWS)) ? '0 : row_inc[ROW_W-1:0];
        enable_state_next  = 1'b1;
        loaded_next        = 1'b1;
      end
      rd_addr = scan_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      subtick_count <= '0;
      scan_row      <= '0;
      enable_state  <= 1'b0;
    end else if (in_xfer) begin
      subtick_count <= subtick_count_next;
      scan_row      <= scan_row_next;
      enable_state  <= enable_state_next;
    end
  end

  // frame store
  logic [31:0]      frame_mem [ROWS];
  logic [31:0]      mem_q;
  logic [ROWS-1:0]  row_valid;
  logic             wr_en;
  logic [ROW_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= wr_data;
    end
    if (in_xfer) begin
      mem_q <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  // modify stage
  logic             s1_valid;
  logic [ACT_W-1:0] s1_act;
  logic [COL_W-1:0] s1_x;
  logic [ROW_W-1:0] s1_addr;
  logic             s1_ok;
  logic             s1_en;
  logic [ROW_W-1:0] s1_row;
  logic             s1_loaded;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_act    <= in_act;
      s1_x      <= in_x;
      s1_addr   <= rd_addr;
      s1_ok     <= pixel_ok;
      s1_en     <= enable_state_next;
      s1_row    <= scan_row_next;
      s1_loaded <= loaded_next;
    end
  end

  // bypass of the write made in the previous cycle
  logic             fwd_en;
  logic [ROW_W-1:0] fwd_addr;
  logic [31:0]      fwd_data;
  logic [31:0]      base_word;
  logic [31:0]      bit_mask;
  logic [31:0]      latched_row_bits;
  logic [31:0]      out_bits;

  always_comb begin
    if (fwd_en && fwd_addr == s1_addr) begin
      base_word = fwd_data;
    end else if (row_valid[s1_addr]) begin
      base_word = mem_q;
    end else begin
      base_word = '0;
    end
    bit_mask = 32'h8000_0000 >> s1_x;
    case (s1_act)
      ACT_SET:    wr_data = base_word | bit_mask;
      ACT_CLEAR:  wr_data = base_word & ~bit_mask;
      ACT_TOGGLE: wr_data = base_word ^ bit_mask;
      default:    wr_data = base_word;
    endcase
    wr_en    = s1_valid && s1_act != ACT_TICK && s1_ok;
    wr_addr  = s1_addr;
    out_bits = s1_loaded ? (base_word & COL_MASK) : latched_row_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_en           <= 1'b0;
      latched_row_bits <= '0;
    end else begin
      fwd_en <= wr_en;
      if (s1_valid) begin
        latched_row_bits <= out_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

  // result queue
  result_t    q_mem [QDEPTH];
  logic [1:0] q_wr, q_rd, q_count;
  logic       q_pop;
  result_t    head;

  assign q_pop    = m_tvalid && m_tready;
  assign m_tvalid = q_count != 2'd0;
  assign s_tready = ({1'b0, q_count} + {2'b0, s1_valid}) < 3'(QDEPTH);
  assign head     = q_mem[q_rd];
  assign m_tdata  = {3'b000, head.bits, head.row, head.en};
  assign m_tuser  = head.loaded;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[q_wr] <= '{loaded: s1_loaded, bits: out_bits, row: s1_row, en: s1_en};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr    <= '0;
      q_rd    <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        q_wr <= (q_wr == 2'(QDEPTH - 1)) ? '0 : q_wr + 2'd1;
      end
      if (q_pop) begin
        q_rd <= (q_rd == 2'(QDEPTH - 1)) ? '0 : q_rd + 2'd1;
      end
      q_count <= q_count + {1'b0, s1_valid} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

FILE: design/lmsd_checker.sv
`default_nettype none

module lmsd_checker
  import lmsd_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser
);

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // a row load always turns the drivers on
  a_load_enables: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[0])
    else $error("row load with output blanked");

  // padding stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:37] == '0)
    else $error("nonzero padding in result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // with no result waiting, no input in flight blocks the next transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && $past(!s_tvalid) |-> s_tready)
    else $error("input stalled with nothing pending");

endmodule

bind led_matrix_scan_driver lmsd_checker u_lmsd_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lmsd_pkg::*;

  typedef struct packed {
    logic             oe;
    logic [ROW_W-1:0] row;
    logic [31:0]      bits;
    logic             loaded;
  } scan_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [ACT_W-1:0]      s_tuser = ACT_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // scan model state
  logic [31:0]      frame [ROWS];
  logic [TPR_W-1:0] subticks;
  logic [ROW_W-1:0] scan_row;
  logic [31:0]      latched_bits;
  logic             enabled;
  logic [BRT_W-1:0] brightness;
  logic [TPR_W-1:0] period;

  scan_result_t pending_scans [$];
  int mismatches = 0;
  int send_idle_pct = 14;
  int recv_stall_pct = 68;
  int chunk_count = 0;

  led_matrix_scan_driver dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 40) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  function automatic scan_result_t predict_scan(input logic [ACT_W-1:0] act,
                                                input logic [COL_W-1:0] x,
                                                input logic [ROW_W-1:0] y);
    scan_result_t r;
    logic [31:0] pixel;
    r.loaded = 1'b0;
    pixel = 32'h8000_0000 >> x;
    if (act == ACT_TICK) begin
      subticks = subticks + 1'b1;
      if (brightness != '0 && subticks == TPR_W'(brightness)) begin
        enabled = 1'b0;
      end
      if (subticks >= period) begin
        subticks = '0;
        scan_row = (int'(scan_row) + 1 >= ROWS) ? '0 : scan_row + 1'b1;
        latched_bits = frame[scan_row] & COL_MASK;
        enabled = 1'b1;
        r.loaded = 1'b1;
      end
    end else if (int'(y) < ROWS && int'(x) < COLS) begin
      case (act)
        ACT_SET: begin
          frame[y] = frame[y] | pixel;
        end
        ACT_CLEAR: begin
          frame[y] = frame[y] & ~pixel;
        end
        default: begin
          frame[y] = frame[y] ^ pixel;
        end
      endcase
    end
    r.oe = enabled;
    r.row = scan_row;
    r.bits = latched_bits;
    return r;
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [COL_W-1:0] x,
                           input logic [ROW_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {{(IN_DATA_W - ROW_W - COL_W){1'b0}}, y, x};
    do @(posedge clk); while (!s_tready);
    pending_scans.push_back(predict_scan(act, x, y));
  endtask

  task automatic tick(input int n);
    repeat (n) send_item(ACT_TICK, COL_W'($urandom), ROW_W'($urandom));
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input logic last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BRIGHTNESS: begin
        brightness = data[BRT_W-1:0];
      end
      REG_TICKS_PER_ROW: begin
        period = data[TPR_W-1:0];
      end
      default: begin
      end
    endcase
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // unused indexes must be ignored, so every setting also writes one
  task automatic configure(input logic [CFG_W-1:0] bright, input logic [CFG_W-1:0] ticks);
    drain();
    write_reg(REG_BRIGHTNESS, bright, 1'b0);
    write_reg(REG_TICKS_PER_ROW, ticks, 1'b0);
    write_reg(IDX_W'($urandom_range(2 ** IDX_W - 1, REG_TICKS_PER_ROW + 1)),
              CFG_W'($urandom), 1'b1);
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_scans.size() == 0) begin
        report("result with no pending input");
      end else begin
        want = pending_scans.pop_front();
        if (m_tdata[0] !== want.oe)
          report($sformatf("output_enable %b, want %b", m_tdata[0], want.oe));
        if (m_tdata[4:1] !== want.row)
          report($sformatf("row_select %0d, want %0d", m_tdata[4:1], want.row));
        if (m_tdata[36:5] !== want.bits)
          report($sformatf("row_bits %h, want %h", m_tdata[36:5], want.bits));
        if (m_tuser !== want.loaded)
          report($sformatf("row_loaded %b, want %b", m_tuser, want.loaded));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_pixel_actions;
    send_item(ACT_SET, 5'd0, 4'd0);
    send_item(ACT_SET, 5'd31, 4'd15);
    send_item(ACT_TOGGLE, 5'd31, 4'd15);
    send_item(ACT_TOGGLE, 5'd31, 4'd15);
    send_item(ACT_CLEAR, 5'd0, 4'd0);
    send_item(ACT_SET, 5'd0, 4'd1);
    send_item(ACT_SET, 5'd31, 4'd1);
    send_item(ACT_TOGGLE, 5'd17, 4'd2);
  endtask

  task automatic test_fast_scan_no_blank;
    configure(8'd0, 8'd1);
    tick(3);
  endtask

  task automatic test_zero_period;
    configure(8'd0, 8'd0);
    tick(2);
  endtask

  task automatic test_blank_then_advance;
    configure(8'd2, 8'd4);
    tick(4);
  endtask

  task automatic test_blank_and_advance_same_tick;
    configure(8'd3, 8'd3);
    tick(3);
  endtask

  task automatic test_lowered_period;
    configure(8'd15, 8'd255);
    tick(4);
    configure(8'd15, 8'd2);
    tick(1);
  endtask

  task automatic test_random(input int chunks, input int per_chunk);
    logic [CFG_W-1:0] bright;
    logic [CFG_W-1:0] ticks;
    logic [ACT_W-1:0] act;
    repeat (chunks) begin
      case (chunk_count)
        0: begin
          bright = 8'd15;
          ticks = 8'd1;
        end
        1: begin
          bright = 8'd0;
          ticks = 8'd255;
        end
        2: begin
          bright = 8'hFF;
          ticks = 8'd16;
        end
        default: begin
          bright = CFG_W'($urandom);
          ticks = ($urandom_range(7) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(12));
        end
      endcase
      chunk_count++;
      configure(bright, ticks);
      repeat (per_chunk) begin
        act = ($urandom_range(99) < 55) ? ACT_TICK
            : ACT_W'($urandom_range(ACT_TOGGLE, ACT_SET));
        send_item(act, COL_W'($urandom), ROW_W'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < ROWS; i++) frame[i] = '0;
    subticks = '0;
    scan_row = '0;
    latched_bits = '0;
    enabled = 1'b0;
    brightness = BRIGHT_RESET;
    period = PERIOD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_pixel_actions();
    test_fast_scan_no_blank();
    test_zero_period();
    test_blank_then_advance();
    test_blank_and_advance_same_tick();
    test_lowered_period();

    test_random(5, 87);
    drain();
    send_idle_pct = 68;
    recv_stall_pct = 14;
    test_random(5, 87);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(5, 87);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
design/lmsd_pkg.sv
design/led_matrix_scan_driver.sv
design/lmsd_checker.sv
test/testbench.sv
